// File: src/iorc_pkg.sv
package iorc_pkg;

    localparam int NumTimers = 6;
    localparam int PixelDivisorDefault = 2;

    typedef enum logic [3:0] {
        FUNC_TICK     = 4'd0,
        FUNC_HB_START = 4'd1,
        FUNC_HB_END   = 4'd2,
        FUNC_VB_START = 4'd3,
        FUNC_VB_END   = 4'd4,
        FUNC_WR_COUNT = 4'd5,
        FUNC_WR_MODE  = 4'd6,
        FUNC_WR_TGT   = 4'd7,
        FUNC_RD_COUNT = 4'd8,
        FUNC_RD_MODE  = 4'd9
    } func_t;

    localparam logic [15:0] ModeReset   = 16'h0400;
    localparam logic [15:0] ModeIrqN    = 16'h0400;
    localparam logic [15:0] ModeTgtFlag = 16'h0800;
    localparam logic [15:0] ModeOvfFlag = 16'h1000;
    localparam logic [16:0] IrqVbStart  = 17'h00001;
    localparam logic [16:0] IrqVbEnd    = 17'h00800;

    function automatic logic [16:0] irq_bit(input logic [2:0] t);
        case (t)
            3'd0: irq_bit = 17'h00010;
            3'd1: irq_bit = 17'h00020;
            3'd2: irq_bit = 17'h00040;
            3'd3: irq_bit = 17'h04000;
            3'd4: irq_bit = 17'h08000;
            3'd5: irq_bit = 17'h10000;
            default: irq_bit = 17'h0;
        endcase
    endfunction

    typedef struct packed {
        logic [31:0] count;
        logic [31:0] target;
        logic        armed;
        logic [15:0] mode;
        logic        halted;
        logic [7:0]  residue;
    } timer_t;

endpackage

// File: src/iorc_timer.sv
module iorc_timer
    import iorc_pkg::*;
#(
    parameter logic [2:0] IDX = 3'd0,
    parameter int PIXEL_DIVISOR = PixelDivisorDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [3:0]  func,
    input  logic        sel,
    input  logic [31:0] write_value,
    output timer_t      st,
    output logic [16:0] irq
);

    localparam bit Wide = IDX >= 3'd3;
    localparam bit Gated = IDX == 3'd0 || IDX == 3'd1 || IDX == 3'd3;
    localparam logic [32:0] Mx = Wide ? 33'h0ffffffff : 33'h00000ffff;

    timer_t st_reg, st_next;
    logic [16:0] irq_next;

    assign st = st_reg;

    // divisor code: 0 means hblank source
    function automatic logic [8:0] div_of(input logic [15:0] m);
        logic [8:0] d;
        d = 9'd1;
        case (IDX)
            3'd0: d = m[8] ? 9'(PIXEL_DIVISOR) : 9'd1;
            3'd1, 3'd3: d = m[8] ? 9'd0 : 9'd1;
            3'd2: d = m[9] ? 9'd8 : 9'd1;
            default:
                case (m[14:13])
                    2'd0: d = 9'd1;
                    2'd1: d = 9'd8;
                    2'd2: d = 9'd16;
                    default: d = 9'd256;
                endcase
        endcase
        return d;
    endfunction

    always_comb
    begin
        timer_t s;
        logic [32:0] c;
        logic [8:0] d;
        logic do_check;
        logic go_start, go_end;
        logic [15:0] m;
        s = st_reg;
        irq_next = '0;
        c = {1'b0, st_reg.count};
        d = div_of(st_reg.mode);
        do_check = 1'b0;
        go_start = 1'b0;
        go_end = 1'b0;
        m = '0;
        case (func)
            FUNC_TICK:
                if (!st_reg.halted && d != 9'd0) begin
                    do_check = 1'b1;
                    if ({1'b0, st_reg.residue} + 9'd1 >= d) begin
                        s.residue = '0;
                        c = c + 33'd1;
                    end else begin
                        s.residue = st_reg.residue + 8'd1;
                    end
                end
            FUNC_HB_START:
            begin
                if ((IDX == 3'd1 || IDX == 3'd3) && d == 9'd0
                    && !(st_reg.mode[0] && st_reg.halted)) begin
                    do_check = 1'b1;
                    c = c + 33'd1;
                end
                go_start = IDX == 3'd0;
            end
            FUNC_HB_END:   go_end = IDX == 3'd0;
            FUNC_VB_START: go_start = IDX == 3'd1 || IDX == 3'd3;
            FUNC_VB_END:   go_end = IDX == 3'd1 || IDX == 3'd3;
            FUNC_WR_COUNT:
                if (sel) begin
                    s.count = 32'(33'(write_value) & Mx);
                    s.armed = 1'b1;
                end
            FUNC_WR_MODE:
                if (sel) begin
                    m = write_value[15:0] | ModeReset;
                    s.mode = m;
                    if (Gated) s.halted = m[0];
                    else s.halted = m[2:0] == 3'd7 || m[2:0] == 3'd1;
                    s.count = '0;
                    s.residue = '0;
                    s.armed = 1'b1;
                end
            FUNC_WR_TGT:
                if (sel) begin
                    s.target = 32'(33'(write_value) & Mx);
                    s.armed = s.target > st_reg.count;
                end
            default: ;
        endcase

        if (do_check) begin
            if (st_reg.armed && c >= {1'b0, st_reg.target}) begin
                if (st_reg.mode[4]) begin
                    s.mode = s.mode | ModeTgtFlag;
                    if (s.mode[7]) s.mode = s.mode & ~ModeIrqN;
                    irq_next = irq_bit(IDX);
                end
                if (st_reg.mode[3]) begin
                    c = c - {1'b0, st_reg.target};
                    if (!st_reg.mode[6]) s.armed = 1'b0;
                end else begin
                    s.armed = 1'b0;
                end
            end
            if (c > Mx) begin
                if (s.mode[5]) begin
                    s.mode = s.mode | ModeOvfFlag;
                    if (s.mode[7]) s.mode = s.mode & ~ModeIrqN;
                    irq_next = irq_bit(IDX);
                end
                c = c & Mx;
                s.target = 32'(33'(st_reg.target) & Mx);
                s.armed = 1'b1;
            end
            s.count = c[31:0];
        end

        if (go_start && st_reg.mode[0]) begin
            case (st_reg.mode[2:1])
                2'd0: s.halted = 1'b1;
                2'd2: begin s.count = '0; s.residue = '0; s.halted = 1'b0; end
                default: ;
            endcase
        end
        if (go_end && st_reg.mode[0]) begin
            case (st_reg.mode[2:1])
                2'd0, 2'd1: begin s.count = '0; s.residue = '0; s.halted = 1'b0; end
                2'd2: s.halted = 1'b1;
                default:
                    if (st_reg.halted) begin
                        s.count = '0; s.residue = '0; s.halted = 1'b0;
                    end
            endcase
        end
        st_next = s;
    end

    assign irq = en ? irq_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            st_reg <= '{count: '0, target: '0, armed: 1'b0, mode: ModeReset,
                        halted: 1'b0, residue: '0};
        end else if (en) begin
            st_reg <= st_next;
        end
    end

endmodule

// File: src/io_root_counter_bank_core.sv
// Channel  Signals                              Direction
// -------  -----------------------------------  ---------
// in       in_valid/in_ready, func, timer_index, write_value  into block
// out      out_valid/out_ready, read_data, irq_raised       out of block
//
// One beat in, one beat out; the result is registered, one item per cycle while out_ready allows.
// The timer registers update at the edge that accepts the beat, so the
// next beat sees the new state at once; the result register holds the
// answer until taken. in_ready is high while the result register is empty
// or being drained, so a stalled output stops input only then.
// Reset clears all timers (mode 0x0400) and empties the result register.
module io_root_counter_bank_core
    import iorc_pkg::*;
#(
    parameter int PIXEL_DIVISOR = PixelDivisorDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  func,
    input  logic [2:0]  timer_index,
    input  logic [31:0] write_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic [16:0] irq_raised
);

    logic        accept;
    logic        out_valid_reg;
    logic [31:0] read_data_reg, read_data_next;
    logic [16:0] irq_reg, irq_next;
    timer_t      st [NumTimers];
    logic [16:0] tirq [NumTimers];

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;

    // one timer cell per counter; each sees every beat
    for (genvar g = 0; g < NumTimers; g++)
    begin : g_tmr
        iorc_timer #(.IDX(3'(g)), .PIXEL_DIVISOR(PIXEL_DIVISOR)) u_tmr (
            .clk(clk), .rst_n(rst_n), .en(accept), .func(func),
            .sel(timer_index == 3'(g)), .write_value(write_value),
            .st(st[g]), .irq(tirq[g])
        );
    end

    always_comb
    begin
        irq_next = '0;
        for (int i = 0; i < NumTimers; i++) irq_next = irq_next | tirq[i];
        if (func == FUNC_VB_START) irq_next = irq_next | IrqVbStart;
        if (func == FUNC_VB_END) irq_next = irq_next | IrqVbEnd;
        read_data_next = '0;
        if (timer_index < 3'(NumTimers)) begin
            // select the timer by index; narrow counts are stored masked
            if (func == FUNC_RD_COUNT)
                read_data_next = st[timer_index].count;
            else if (func == FUNC_RD_MODE)
                read_data_next = {16'h0, st[timer_index].mode};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            read_data_reg <= read_data_next;
            irq_reg <= irq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign irq_raised = irq_reg;

endmodule
